@@ rtl/wssm_pkg.sv @@
// Shared types and constants of the working-set slot manager.
// Holds the beat structs, operation and result codes, the sequencer states
// and the lane status records. Depends on nothing.
package wssm_pkg;

  localparam int unsigned SLOT_COUNT_DEF  = 8;
  localparam int unsigned SET_ENTRIES_DEF = 5;
  localparam int unsigned FILE_BITS_DEF   = 16;

  localparam int unsigned SET_ENTRIES_MAX = 5;
  localparam int unsigned FILE_BITS_MAX   = 32;
  localparam int unsigned SLOT_IDX_W_MAX  = 4;
  localparam int unsigned FIELD_W         = 16;
  localparam int unsigned SOUND_W         = 8;

  localparam logic [SOUND_W-1:0] SOUND_BASE = 8'd44;
  localparam logic [SOUND_W-1:0] SOUND_MISS = 8'hFF;

  typedef enum logic {
    OP_TRANSITION = 1'b0,
    OP_LOOKUP     = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_NONE = 2'd1,
    KIND_HIT  = 2'd2,
    KIND_MISS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FREE,
    ST_PEND,
    ST_ALLOC
  } state_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [FIELD_W-1:0]   old_file_a;
    logic [FIELD_W-1:0]   old_file_b;
    logic [FIELD_W-1:0]   old_file_c;
    logic [FIELD_W-1:0]   old_file_d;
    logic [FIELD_W-1:0]   old_file_e;
    logic [FIELD_W-1:0]   new_file_a;
    logic [FIELD_W-1:0]   new_file_b;
    logic [FIELD_W-1:0]   new_file_c;
    logic [FIELD_W-1:0]   new_file_d;
    logic [FIELD_W-1:0]   new_file_e;
    logic [FIELD_W-1:0]   lookup_key;
  } in_beat_t;

  typedef struct packed {
    kind_e                kind;
    logic [2:0]           slot;
    logic [FIELD_W-1:0]   file_id;
    logic [SOUND_W-1:0]   sound_number;
    logic                 last;
  } out_beat_t;

  // Commands from the sequencer to one slot lane.
  typedef struct packed {
    logic clear_stale;
    logic write;
  } lane_ctl_t;

  // What one slot lane found about its resident file.
  typedef struct packed {
    logic                       occupied;
    logic                       keep;
    logic                       key_hit;
    logic [SET_ENTRIES_MAX-1:0] new_hit;
  } lane_stat_t;

  // Combined view of all lanes.
  typedef struct packed {
    logic                       hit_found;
    logic [SLOT_IDX_W_MAX-1:0]  hit_slot;
    logic                       free_found;
    logic [SLOT_IDX_W_MAX-1:0]  free_slot;
    logic                       free_multi;
    logic [SET_ENTRIES_MAX-1:0] resident;
  } merge_t;

endpackage

@@ rtl/wssm_slot_lane.sv @@
// One resident-file slot with its compare logic against both file lists
// and the lookup key. Depends on wssm_pkg.
module wssm_slot_lane #(
  parameter int unsigned FileBits   = wssm_pkg::FILE_BITS_DEF,
  parameter int unsigned SetEntries = wssm_pkg::SET_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wssm_pkg::lane_ctl_t  ctl_i,
  input  logic [FileBits-1:0]  wr_file_i,
  input  logic [FileBits-1:0]  old_list_i [SetEntries],
  input  logic [FileBits-1:0]  new_list_i [SetEntries],
  input  logic [FileBits-1:0]  key_i,
  output wssm_pkg::lane_stat_t stat_o
);
  import wssm_pkg::*;

  localparam logic [FileBits-1:0] NoneFile = '1;

  logic [FileBits-1:0]        file_q, file_d;
  logic                       in_old, in_new, occupied;
  logic [SET_ENTRIES_MAX-1:0] new_hit;

  always_comb begin
    in_old  = 1'b0;
    in_new  = 1'b0;
    new_hit = '0;
    for (int i = 0; i < SetEntries; i++) begin
      if (old_list_i[i] != NoneFile && old_list_i[i] == file_q) begin
        in_old = 1'b1;
      end
      if (new_list_i[i] != NoneFile && new_list_i[i] == file_q) begin
        in_new     = 1'b1;
        new_hit[i] = 1'b1;
      end
    end
  end

  assign occupied = (file_q != NoneFile);

  always_comb begin
    file_d = file_q;
    if (ctl_i.write) begin
      file_d = wr_file_i;
    end else if (ctl_i.clear_stale && occupied && !(in_old || in_new)) begin
      file_d = NoneFile;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_q <= NoneFile;
    end else begin
      file_q <= file_d;
    end
  end

  assign stat_o.occupied = occupied;
  assign stat_o.keep     = in_old || in_new;
  assign stat_o.key_hit  = (file_q == key_i);
  assign stat_o.new_hit  = new_hit;

endmodule

@@ rtl/wssm_merge.sv @@
// Merging stage: lowest hit slot, lowest free slot, more than one free slot
// and residency of each new-list entry across all lanes. Depends on wssm_pkg.
module wssm_merge #(
  parameter int unsigned SlotCount = wssm_pkg::SLOT_COUNT_DEF
) (
  input  wssm_pkg::lane_stat_t stat_i [SlotCount],
  output wssm_pkg::merge_t     merge_o
);
  import wssm_pkg::*;

  logic [SlotCount-1:0] free_vec;

  always_comb begin
    merge_o  = '0;
    free_vec = '0;
    // Walk from the top so that the lowest matching slot wins.
    for (int s = SlotCount - 1; s >= 0; s--) begin
      free_vec[s] = !stat_i[s].occupied;
      if (stat_i[s].key_hit) begin
        merge_o.hit_found = 1'b1;
        merge_o.hit_slot  = SLOT_IDX_W_MAX'(s);
      end
      if (!stat_i[s].occupied) begin
        merge_o.free_found = 1'b1;
        merge_o.free_slot  = SLOT_IDX_W_MAX'(s);
      end
      merge_o.resident = merge_o.resident | stat_i[s].new_hit;
    end
    merge_o.free_multi = |(free_vec & (free_vec - 1'b1));
  end

endmodule

@@ rtl/working_set_slot_manager.sv @@
// Top level of the working-set slot manager: input capture, sequencer,
// slot lanes, merging stage and output register. Depends on wssm_pkg,
// wssm_slot_lane and wssm_merge.
//
// The block keeps SlotCount resident-file slots, all empty after reset.
// A lookup beat takes a capture step, then one parallel compare in all
// lanes whose lowest hit goes to the output register. A transition beat
// returns n results (at least one) through these steps: capture, a step
// that frees every slot whose file is in neither list, a step that marks
// which new-list files are not resident, and then one step per load, since
// the allocation stage writes one slot per cycle, while the output is not
// stalled, through the shared lowest-free-slot search. A transition that
// loads nothing returns a single "nothing to load" beat. Input beats are
// taken only while the sequencer is idle; the output register holds a
// finished result until the receiver takes it, and a stall on the output
// side holds the lookup and allocation steps. The last result of every
// item carries last.
module working_set_slot_manager #(
  parameter int unsigned SlotCount  = wssm_pkg::SLOT_COUNT_DEF,
  parameter int unsigned SetEntries = wssm_pkg::SET_ENTRIES_DEF,
  parameter int unsigned FileBits   = wssm_pkg::FILE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wssm_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wssm_pkg::out_beat_t out_beat_o
);
  import wssm_pkg::*;

  localparam int unsigned SetIdxW = (SetEntries > 1) ? $clog2(SetEntries) : 1;
  localparam logic [FileBits-1:0] NoneFile = '1;

  // Input fields are taken in FileBits bits: truncated or zero-extended.
  function automatic logic [FileBits-1:0] to_file(input logic [FIELD_W-1:0] f);
    logic [FILE_BITS_MAX-1:0] w;
    w = FILE_BITS_MAX'(f);
    return w[FileBits-1:0];
  endfunction

  state_e state_q, state_d;

  logic [FileBits-1:0]   old_q [SetEntries];
  logic [FileBits-1:0]   new_q [SetEntries];
  logic [FileBits-1:0]   key_q;
  logic [SetEntries-1:0] pend_q, pend_d;

  logic      out_valid_q;
  out_beat_t out_q;
  out_beat_t res;
  logic      emit, out_free, load_in, clear_stale, wr_en;

  logic [FIELD_W-1:0] old_raw [SET_ENTRIES_MAX];
  logic [FIELD_W-1:0] new_raw [SET_ENTRIES_MAX];

  logic [SetIdxW-1:0]       pick_idx;
  logic [SetEntries-1:0]    pick_oh;
  logic                     pend_single;
  logic [FileBits-1:0]      wr_file;
  logic [FILE_BITS_MAX-1:0] wr_file_wide;

  lane_ctl_t  lane_ctl  [SlotCount];
  lane_stat_t lane_stat [SlotCount];
  logic [SlotCount-1:0] wr_vec;
  merge_t     merge;

  assign old_raw[0] = in_beat_i.old_file_a;
  assign old_raw[1] = in_beat_i.old_file_b;
  assign old_raw[2] = in_beat_i.old_file_c;
  assign old_raw[3] = in_beat_i.old_file_d;
  assign old_raw[4] = in_beat_i.old_file_e;
  assign new_raw[0] = in_beat_i.new_file_a;
  assign new_raw[1] = in_beat_i.new_file_b;
  assign new_raw[2] = in_beat_i.new_file_c;
  assign new_raw[3] = in_beat_i.new_file_d;
  assign new_raw[4] = in_beat_i.new_file_e;

  // Capture registers; the lanes compare against these, never the port.
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      for (int i = 0; i < SetEntries; i++) begin
        old_q[i] <= to_file(old_raw[i]);
        new_q[i] <= to_file(new_raw[i]);
      end
      key_q <= to_file(in_beat_i.lookup_key);
    end
  end

  // Slot lanes, one per resident slot, all comparing in parallel.
  for (genvar s = 0; s < SlotCount; s++) begin : g_lane
    assign wr_vec[s] = wr_en && (merge.free_slot == SLOT_IDX_W_MAX'(s));
    assign lane_ctl[s].clear_stale = clear_stale;
    assign lane_ctl[s].write       = wr_vec[s];

    wssm_slot_lane #(
      .FileBits   (FileBits),
      .SetEntries (SetEntries)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl[s]),
      .wr_file_i  (wr_file),
      .old_list_i (old_q),
      .new_list_i (new_q),
      .key_i      (key_q),
      .stat_o     (lane_stat[s])
    );
  end

  wssm_merge #(
    .SlotCount (SlotCount)
  ) u_merge (
    .stat_i  (lane_stat),
    .merge_o (merge)
  );

  // Lowest pending new-list entry; entries are loaded in list order.
  always_comb begin
    pick_idx = '0;
    pick_oh  = '0;
    for (int i = SetEntries - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        pick_idx = SetIdxW'(i);
      end
    end
    for (int i = 0; i < SetEntries; i++) begin
      if (pend_q[i] && (pick_idx == SetIdxW'(i))) begin
        pick_oh[i] = 1'b1;
      end
    end
  end

  assign pend_single  = ((pend_q & (pend_q - 1'b1)) == '0);
  assign wr_file      = new_q[pick_idx];
  assign wr_file_wide = FILE_BITS_MAX'(wr_file);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: next state and per-cycle commands.
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    emit        = 1'b0;
    res         = '0;
    load_in     = 1'b0;
    clear_stale = 1'b0;
    wr_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          state_d = (in_beat_i.opcode == OP_LOOKUP) ? ST_LOOKUP : ST_FREE;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          emit     = 1'b1;
          res.last = 1'b1;
          if (merge.hit_found && (key_q != NoneFile)) begin
            res.kind         = KIND_HIT;
            res.slot         = merge.hit_slot[2:0];
            res.sound_number = SOUND_BASE + SOUND_W'(merge.hit_slot);
          end else begin
            res.kind         = KIND_MISS;
            res.sound_number = SOUND_MISS;
          end
          state_d = ST_IDLE;
        end
      end
      ST_FREE: begin
        clear_stale = 1'b1;
        state_d     = ST_PEND;
      end
      ST_PEND: begin
        for (int i = 0; i < SetEntries; i++) begin
          pend_d[i] = (new_q[i] != NoneFile) && !merge.resident[i];
        end
        state_d = ST_ALLOC;
      end
      ST_ALLOC: begin
        if (out_free) begin
          emit = 1'b1;
          if ((pend_q == '0) || !merge.free_found) begin
            // Only reached when this transition has loaded nothing.
            res.kind = KIND_NONE;
            res.last = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            wr_en       = 1'b1;
            res.kind    = KIND_LOAD;
            res.slot    = merge.free_slot[2:0];
            res.file_id = wr_file_wide[FIELD_W-1:0];
            res.last    = pend_single || !merge.free_multi;
            pend_d      = pend_q & ~pick_oh;
            if (res.last) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef ASSERT_OFF
  // A waiting result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("result produced while the output register is stalled");

  // At most one slot lane is written per cycle.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_vec))
    else $error("more than one slot written in a cycle");

  // The final result of an item returns the sequencer to idle.
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && res.last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after the final result");

  // A hit is never reported for the empty-slot file number.
  a_hit_real_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (res.kind == KIND_HIT)) |-> (key_q != NoneFile))
    else $error("lookup hit on the empty-slot value");
`endif

endmodule

@@ verif/tb_working_set_slot_manager.sv @@
// Self-checking testbench of working_set_slot_manager: drives transition and
// lookup beats, predicts every result beat from its own slot model and checks it.
// Depends on wssm_pkg and the block's RTL.
module tb_working_set_slot_manager;
  import wssm_pkg::*;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned SET_N        = 5;
  localparam logic [FIELD_W-1:0] NO_FILE = '1;
  // Watchdog limit. Even with long stalls on both sides a correct run needs
  // far fewer cycles than this.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;

  // One working-set list, entry 0 is the "a" field.
  typedef logic [SET_N-1:0][FIELD_W-1:0] file_list_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  working_set_slot_manager u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  // Clock with a period of 8 time units.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus and prediction state. The driver pops beats from the command
  // queue; every accepted beat is run through the slot model, which pushes
  // the result beats the block must return, in order.
  in_beat_t    command_q[$];
  out_beat_t   expected_beats_q[$];
  logic [FIELD_W-1:0] model_slot_file [SLOTS];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Generator state: a pool of file numbers so that sets overlap, and the
  // working set that the last transition made current.
  logic [FIELD_W-1:0] file_pool [12];
  file_list_t         live_set;

  // True when file f appears in the list; the none value never matches.
  function automatic bit listed(file_list_t l, logic [FIELD_W-1:0] f);
    for (int i = 0; i < SET_N; i++) begin
      if (l[i] != NO_FILE && l[i] == f) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the slot model with one accepted beat and queues its results.
  function automatic void apply_to_slot_model(in_beat_t b);
    file_list_t         old_l;
    file_list_t         new_l;
    logic [FIELD_W-1:0] pend [SET_N];
    bit                 used [SLOTS];
    out_beat_t          res  [SET_N];
    int                 np;
    int                 n;
    bit                 found;

    np = 0;
    n = 0;
    if (b.opcode == OP_LOOKUP) begin
      res[0] = '0;
      res[0].kind = KIND_MISS;
      res[0].sound_number = SOUND_MISS;
      res[0].last = 1'b1;
      // A lookup of the none value always misses; otherwise the lowest
      // slot holding the key wins.
      if (b.lookup_key != NO_FILE) begin
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (model_slot_file[s] == b.lookup_key) begin
            res[0].kind = KIND_HIT;
            res[0].slot = 3'(s);
            res[0].sound_number = SOUND_BASE + 8'(s);
          end
        end
      end
      expected_beats_q.push_back(res[0]);
      return;
    end

    old_l = {b.old_file_e, b.old_file_d, b.old_file_c, b.old_file_b, b.old_file_a};
    new_l = {b.new_file_e, b.new_file_d, b.new_file_c, b.new_file_b, b.new_file_a};

    // Free every slot whose file is in neither set.
    for (int s = 0; s < SLOTS; s++) begin
      if (model_slot_file[s] != NO_FILE && !listed(old_l, model_slot_file[s]) &&
          !listed(new_l, model_slot_file[s])) begin
        model_slot_file[s] = NO_FILE;
      end
    end

    // New-set files not resident after freeing. Duplicates are all kept,
    // so each copy gets its own slot.
    for (int i = 0; i < SET_N; i++) begin
      found = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        if (model_slot_file[s] == new_l[i]) found = 1'b1;
      end
      if (new_l[i] != NO_FILE && !found) begin
        pend[np] = new_l[i];
        np++;
      end
    end

    for (int s = 0; s < SLOTS; s++) used[s] = (model_slot_file[s] != NO_FILE);

    // Lowest free slot per pending file; a file with no free slot is dropped.
    for (int i = 0; i < np; i++) begin
      found = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        if (!found && !used[s]) begin
          found = 1'b1;
          used[s] = 1'b1;
          model_slot_file[s] = pend[i];
          res[n] = '0;
          res[n].kind = KIND_LOAD;
          res[n].slot = 3'(s);
          res[n].file_id = pend[i];
          n++;
        end
      end
    end

    if (n == 0) begin
      res[0] = '0;
      res[0].kind = KIND_NONE;
      n = 1;
    end
    res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_beats_q.push_back(res[i]);
  endfunction

  function automatic file_list_t set_of(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                        logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d,
                                        logic [FIELD_W-1:0] e);
    return {e, d, c, b, a};
  endfunction

  // Transition beat; the lookup key is don't-care and gets random bits.
  function automatic in_beat_t transition_beat(file_list_t old_l, file_list_t new_l);
    in_beat_t b;
    b = '0;
    b.opcode = OP_TRANSITION;
    {b.old_file_e, b.old_file_d, b.old_file_c, b.old_file_b, b.old_file_a} = old_l;
    {b.new_file_e, b.new_file_d, b.new_file_c, b.new_file_b, b.new_file_a} = new_l;
    b.lookup_key = FIELD_W'($urandom);
    return b;
  endfunction

  // Lookup beat; both lists are don't-care and get random bits.
  function automatic in_beat_t lookup_beat(logic [FIELD_W-1:0] key);
    in_beat_t b;
    b = transition_beat(file_list_t'({$urandom, $urandom, $urandom}),
                        file_list_t'({$urandom, $urandom, $urandom}));
    b.opcode = OP_LOOKUP;
    b.lookup_key = key;
    return b;
  endfunction

  // Mostly pool files, some none values and some wide random numbers.
  function automatic logic [FIELD_W-1:0] pick_file();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return file_pool[$urandom_range(11)];
    if (r < 88) return NO_FILE;
    return FIELD_W'($urandom);
  endfunction

  // Well-formed traffic: the old list is the current working set and the new
  // list keeps part of it. A share of the transitions carry a noisy old list.
  function automatic void queue_random_items(int unsigned count);
    file_list_t old_l;
    file_list_t new_l;
    logic [FIELD_W-1:0] key;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) file_pool[$urandom_range(11)] = FIELD_W'($urandom);
      if ($urandom_range(99) < 55) begin
        for (int i = 0; i < SET_N; i++) begin
          old_l[i] = ($urandom_range(99) < 80) ? live_set[i] : pick_file();
          new_l[i] = ($urandom_range(99) < 35) ? live_set[$urandom_range(SET_N - 1)]
                                               : pick_file();
        end
        command_q.push_back(transition_beat(old_l, new_l));
        live_set = new_l;
      end else begin
        case ($urandom_range(3)) inside
          0, 1: key = live_set[$urandom_range(SET_N - 1)];
          2:    key = pick_file();
          default: key = FIELD_W'($urandom);
        endcase
        command_q.push_back(lookup_beat(key));
      end
    end
  endfunction

  // Holds the stimulus until every queued beat is taken and every expected
  // result beat has come back. The check runs on the falling edge, when the
  // driver and the monitor have settled for the cycle.
  task automatic wait_for_drain();
    while (command_q.size() != 0 || in_valid || expected_beats_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver. A beat stays on the port until it is accepted; only then may the
  // next beat or an idle cycle follow, so valid never reacts to stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_slot_model(in_beat);
      end
      if (!in_valid || !in_stall) begin
        if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= command_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted result beat is checked field by field against
  // the oldest expected beat. The receiver stalls at random.
  out_beat_t oldest_beat;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats_q.size() == 0) begin
          $error("result beat with no expected beat pending: %p", out_beat);
          mismatch_count++;
        end else begin
          oldest_beat = expected_beats_q.pop_front();
          if (out_beat.kind != oldest_beat.kind) begin
            $error("kind: expected %0d, actual %0d", oldest_beat.kind, out_beat.kind);
            mismatch_count++;
          end
          if (out_beat.slot != oldest_beat.slot) begin
            $error("slot: expected %0d, actual %0d", oldest_beat.slot, out_beat.slot);
            mismatch_count++;
          end
          if (out_beat.file_id != oldest_beat.file_id) begin
            $error("file_id: expected %h, actual %h", oldest_beat.file_id,
                   out_beat.file_id);
            mismatch_count++;
          end
          if (out_beat.sound_number != oldest_beat.sound_number) begin
            $error("sound_number: expected %0d, actual %0d", oldest_beat.sound_number,
                   out_beat.sound_number);
            mismatch_count++;
          end
          if (out_beat.last != oldest_beat.last) begin
            $error("last: expected %0d, actual %0d", oldest_beat.last, out_beat.last);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) model_slot_file[s] = NO_FILE;
    for (int i = 0; i < 12; i++) file_pool[i] = FIELD_W'(i);
    file_pool[10] = 16'hFFFE;
    file_pool[11] = FIELD_W'($urandom);
    live_set = set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE);

    // Directed part. Lookups on empty slots and of the none value miss.
    command_q.push_back(lookup_beat(16'h0000));
    command_q.push_back(lookup_beat(NO_FILE));
    // Empty lists load nothing.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE)));
    // Five loads into slots zero to four, extreme file numbers among them.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(16'h0000, 16'h0001, 16'hFFFE, 16'h0002,
                                               16'h0003)));
    command_q.push_back(lookup_beat(16'hFFFE));
    // The old set keeps all five files, so only three slots are free and
    // the last two new files are dropped.
    command_q.push_back(transition_beat(set_of(16'h0000, 16'h0001, 16'hFFFE, 16'h0002,
                                               16'h0003),
                                        set_of(16'h0004, 16'h0005, 16'h0006, 16'h0007,
                                               16'h0008)));
    command_q.push_back(lookup_beat(16'h0008));
    command_q.push_back(lookup_beat(16'h0006));
    // Everything is freed; three copies of one file take three slots, and a
    // lookup of that file returns the lowest of them.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(16'h0009, 16'h0009, 16'h0009, NO_FILE,
                                               NO_FILE)));
    command_q.push_back(lookup_beat(16'h0009));
    // Already resident: nothing to load.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(NO_FILE, NO_FILE, 16'h0009, NO_FILE,
                                               NO_FILE)));
    // Files kept by the old set alone, new files in the upper entries.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, 16'h0009),
                                        set_of(NO_FILE, NO_FILE, NO_FILE, 16'hA5A5,
                                               16'h5A5A)));
    command_q.push_back(lookup_beat(16'h5A5A));
    command_q.push_back(lookup_beat(16'hA5A5));
    command_q.push_back(lookup_beat(16'h1234));
    // Both lists empty: every slot is freed.
    command_q.push_back(transition_beat(set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(NO_FILE, NO_FILE, NO_FILE, NO_FILE, NO_FILE)));
    command_q.push_back(lookup_beat(16'h0009));
    // Duplicate of file zero next to a wide number.
    command_q.push_back(transition_beat(set_of(16'hFFFE, NO_FILE, NO_FILE, NO_FILE, NO_FILE),
                                        set_of(16'h0000, 16'hFFFE, 16'h0000, NO_FILE,
                                               NO_FILE)));
    command_q.push_back(lookup_beat(16'h0000));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats run without idling; then the three random phases. The
    // drain between phases is also the point where the sender waits until
    // every expected result beat has arrived.
    wait_for_drain();
    send_idle_pct = 31;
    recv_idle_pct = 55;
    queue_random_items(47);
    wait_for_drain();
    send_idle_pct = 55;
    recv_idle_pct = 31;
    queue_random_items(47);
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(47);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/wssm_pkg.sv
rtl/wssm_slot_lane.sv
rtl/wssm_merge.sv
rtl/working_set_slot_manager.sv
verif/tb_working_set_slot_manager.sv
